### hdl/rrtt_pkg.sv
// Package for the round-robin task table: request and result words,
// request and status codes, and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package rrtt_pkg;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_START  = 2'd1,
    REQ_YIELD  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_NO_PAGE     = 3'd2,
    ST_NONE_READY  = 3'd3,
    ST_NOT_STARTED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        page_granted;
    logic [31:0] stack_word;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] task_id;
    logic [2:0]  slot_index;
    logic        switched;
    logic [31:0] resume_stack;
  } res_t;

  typedef struct packed {
    logic load;
    logic found;
    logic step;
    logic rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       run_valid;
    logic       hit;
    logic       last;
  } sts_t;

endpackage

`default_nettype wire

### hdl/rrtt_ctrl.sv
// Controller for the round-robin task table: sequences request capture,
// the slot scan, the table read and the commit. Depends on rrtt_pkg.
`default_nettype none

module rrtt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rrtt_pkg::sts_t sts_i,
  output rrtt_pkg::cmd_t     cmd_o
);
  import rrtt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       skip;

  assign skip = (sts_i.req == REQ_CLEAR) || ((sts_i.req == REQ_YIELD) && !sts_i.run_valid);
  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (skip) begin
          state_d = S_DONE;
        end else if (sts_i.hit) begin
          cmd_o.found = 1'b1;
          state_d     = S_READ;
        end else if (sts_i.last) begin
          state_d = S_READ;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/rrtt_datapath.sv
// Datapath for the round-robin task table: slot flags, id and stack memories,
// scan pointer, running-task registers and the result register. Depends on rrtt_pkg.
`default_nettype none

module rrtt_datapath #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rrtt_pkg::req_t req_i,
  input  wire rrtt_pkg::cmd_t cmd_i,
  output rrtt_pkg::sts_t      sts_o,
  output logic                done_o,
  output rrtt_pkg::res_t      res_o
);
  import rrtt_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [31:0] id_mem  [SLOTS];
  logic [31:0] stk_mem [SLOTS];

  req_t             req_q;
  logic [SLOTS-1:0] used_q, used_d;
  logic [SLOTS-1:0] rdy_q, rdy_d;
  logic             run_valid_q, run_valid_d;
  logic [IW-1:0]    run_slot_q, run_slot_d;
  logic [31:0]      id_ctr_q, id_ctr_d;
  logic [IW-1:0]    ptr_q, cnt_q, hit_q;
  logic             found_q;
  logic [31:0]      rd_id_q, rd_stk_q;
  res_t             res_q, res_d;
  logic             done_q;

  logic [IW-1:0]    run_next, ptr_next, rd_addr, stk_wa;
  logic             id_we, stk_we;

  assign run_next = (run_slot_q == LAST) ? '0 : IW'(run_slot_q + IW'(1));
  assign ptr_next = (ptr_q == LAST) ? '0 : IW'(ptr_q + IW'(1));
  assign rd_addr  = found_q ? hit_q : run_slot_q;

  assign sts_o.req       = req_q.req_type;
  assign sts_o.run_valid = run_valid_q;
  assign sts_o.hit       = (req_q.req_type == REQ_CREATE) ? !used_q[ptr_q] : rdy_q[ptr_q];
  assign sts_o.last      = (cnt_q == LAST);

  always_comb begin
    used_d      = used_q;
    rdy_d       = rdy_q;
    run_valid_d = run_valid_q;
    run_slot_d  = run_slot_q;
    id_ctr_d    = id_ctr_q;
    res_d       = '0;
    id_we       = 1'b0;
    stk_we      = 1'b0;
    stk_wa      = hit_q;
    if (cmd_i.commit) begin
      case (req_q.req_type)
        REQ_CREATE: begin
          if (!found_q) begin
            res_d.status = ST_FULL;
          end else if (!req_q.page_granted) begin
            res_d.status = ST_NO_PAGE;
          end else begin
            used_d[hit_q]    = 1'b1;
            rdy_d[hit_q]     = 1'b1;
            id_we            = 1'b1;
            stk_we           = 1'b1;
            id_ctr_d         = id_ctr_q + 32'd1;
            res_d.status     = ST_OK;
            res_d.task_id    = id_ctr_q;
            res_d.slot_index = 3'(hit_q);
          end
        end
        REQ_START: begin
          if (!found_q) begin
            res_d.status = ST_NONE_READY;
          end else begin
            rdy_d[hit_q]       = 1'b0;
            run_valid_d        = 1'b1;
            run_slot_d         = hit_q;
            res_d.status       = ST_OK;
            res_d.task_id      = rd_id_q;
            res_d.slot_index   = 3'(hit_q);
            res_d.switched     = 1'b1;
            res_d.resume_stack = rd_stk_q;
          end
        end
        REQ_YIELD: begin
          if (!run_valid_q) begin
            res_d.status = ST_NOT_STARTED;
          end else if (!found_q) begin
            res_d.status     = ST_NONE_READY;
            res_d.task_id    = rd_id_q;
            res_d.slot_index = 3'(run_slot_q);
          end else begin
            stk_we             = 1'b1;
            stk_wa             = run_slot_q;
            rdy_d[run_slot_q]  = 1'b1;
            rdy_d[hit_q]       = 1'b0;
            run_slot_d         = hit_q;
            res_d.status       = ST_OK;
            res_d.task_id      = rd_id_q;
            res_d.slot_index   = 3'(hit_q);
            res_d.switched     = 1'b1;
            res_d.resume_stack = rd_stk_q;
          end
        end
        default: begin
          used_d      = '0;
          rdy_d       = '0;
          run_valid_d = 1'b0;
          run_slot_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      rdy_q       <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      id_ctr_q    <= 32'd1;
      found_q     <= 1'b0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      used_q      <= used_d;
      rdy_q       <= rdy_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      id_ctr_q    <= id_ctr_d;
      done_q      <= cmd_i.commit;
      if (cmd_i.load) begin
        found_q <= 1'b0;
        cnt_q   <= '0;
        ptr_q   <= (req_i.req_type == REQ_YIELD) ? run_next : '0;
      end else if (cmd_i.found) begin
        found_q <= 1'b1;
      end else if (cmd_i.step) begin
        ptr_q <= ptr_next;
        cnt_q <= IW'(cnt_q + IW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.found) begin
      hit_q <= ptr_q;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[hit_q] <= id_ctr_q;
    end
    if (stk_we) begin
      stk_mem[stk_wa] <= req_q.stack_word;
    end
    if (cmd_i.rd) begin
      rd_id_q  <= id_mem[rd_addr];
      rd_stk_q <= stk_mem[rd_addr];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

### hdl/round_robin_task_table_unit.sv
// Top level of the round-robin task table: controller plus datapath.
// Depends on rrtt_pkg, rrtt_ctrl and rrtt_datapath.
//
// A request is taken when start is high and busy is low; its single result word
// appears on res_o for exactly one cycle with done_o high, and the receiver cannot
// stall it. After acceptance the controller runs the slot scan, which tests one
// slot per cycle, then one id/stack memory read and the commit; a clear, or a
// yield before start, ends the scan at once and skips the read. A new request
// may be accepted in the cycle the strobe is shown.
`default_nettype none

module round_robin_task_table_unit #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire rrtt_pkg::req_t req_i,
  output logic                done_o,
  output rrtt_pkg::res_t      res_o
);
  import rrtt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrtt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rrtt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

### hdl/rrtt_checker.sv
// Port-level checker for the round-robin task table and its bind to the top level.
// Depends on rrtt_pkg and round_robin_task_table_unit.
`default_nettype none

module rrtt_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire rrtt_pkg::res_t res_o
);
  import rrtt_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("Accepted word did not make the block busy.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result strobe while busy.");

  a_finish_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("Request finished without a result word.");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe held for more than one cycle.");

  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status == ST_FULL || res_o.status == ST_NO_PAGE ||
               res_o.status == ST_NOT_STARTED)
    |-> (res_o.task_id == 32'd0) && (res_o.slot_index == 3'd0) &&
        !res_o.switched && (res_o.resume_stack == 32'd0))
    else $error("Failed request carried non-zero result fields.");

endmodule

bind round_robin_task_table_unit rrtt_checker u_rrtt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the round-robin task table unit.
// Depends on rrtt_pkg and round_robin_task_table_unit; it predicts each result word
// from its own copy of the slot table and checks every result strobe against it.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrtt_pkg::*;

  localparam int unsigned SLOTS = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = SLOTS + 8;
  localparam int unsigned MAX_PRINTED = 40;

  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_READY = 2'd1;
  localparam logic [1:0] SLOT_RUNNING = 2'd2;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  res_t res_o;

  round_robin_task_table_unit #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  logic [1:0]  tbl_state [SLOTS];
  logic [31:0] tbl_id    [SLOTS];
  logic [31:0] tbl_stack [SLOTS];
  logic [31:0] next_id;
  bit          run_valid;
  int unsigned run_slot;
  int unsigned used_slots;

  res_t        expected_q[$];
  bit          quiet;
  int unsigned n_errors;
  int unsigned n_words;
  int unsigned n_sent;
  int unsigned n_switches;
  int unsigned n_req    [4];
  int unsigned n_status [5];
  int unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
               expected_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("Mismatch on %s in word %0d: got %h, expected %h.", what, n_words, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && done_o === 1'b1) begin
      n_words++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(res_o.status), 32'd0);
      end else begin
        want = expected_q.pop_front();
        check_field("status", 32'(res_o.status), 32'(want.status));
        check_field("task_id", res_o.task_id, want.task_id);
        check_field("slot_index", 32'(res_o.slot_index), 32'(want.slot_index));
        check_field("switched", 32'(res_o.switched), 32'(want.switched));
        check_field("resume_stack", res_o.resume_stack, want.resume_stack);
      end
    end
  end

  function automatic void wipe_table();
    for (int unsigned k = 0; k < SLOTS; k++) begin
      tbl_state[k] = SLOT_FREE;
      tbl_id[k] = '0;
      tbl_stack[k] = '0;
    end
    run_valid = 1'b0;
    run_slot = 0;
    used_slots = 0;
  endfunction

  function automatic res_t apply_request(input req_t r);
    res_t o;
    int unsigned idx;
    int unsigned k;
    o = '0;
    idx = SLOTS;
    case (r.req_type)
      REQ_CREATE: begin
        if (used_slots < SLOTS) begin
          for (k = 0; k < SLOTS; k++) begin
            if (idx == SLOTS && tbl_state[k] == SLOT_FREE) idx = k;
          end
        end
        if (idx == SLOTS) begin
          o.status = ST_FULL;
        end else if (!r.page_granted) begin
          o.status = ST_NO_PAGE;
        end else begin
          tbl_id[idx] = next_id;
          next_id = next_id + 32'd1;
          tbl_state[idx] = SLOT_READY;
          tbl_stack[idx] = r.stack_word;
          used_slots++;
          o.status = ST_OK;
          o.task_id = tbl_id[idx];
          o.slot_index = 3'(idx);
        end
      end
      REQ_START: begin
        for (k = 0; k < SLOTS; k++) begin
          if (idx == SLOTS && tbl_state[k] == SLOT_READY) idx = k;
        end
        if (idx == SLOTS) begin
          o.status = ST_NONE_READY;
        end else begin
          run_valid = 1'b1;
          run_slot = idx;
          tbl_state[idx] = SLOT_RUNNING;
          o.status = ST_OK;
          o.task_id = tbl_id[idx];
          o.slot_index = 3'(idx);
          o.switched = 1'b1;
          o.resume_stack = tbl_stack[idx];
        end
      end
      REQ_YIELD: begin
        if (!run_valid) begin
          o.status = ST_NOT_STARTED;
        end else begin
          if (used_slots != 0) begin
            for (k = 1; k <= SLOTS; k++) begin
              if (idx == SLOTS && tbl_state[(run_slot + k) % SLOTS] == SLOT_READY)
                idx = (run_slot + k) % SLOTS;
            end
          end
          if (idx == SLOTS) begin
            o.status = ST_NONE_READY;
            o.task_id = tbl_id[run_slot];
            o.slot_index = 3'(run_slot);
          end else begin
            tbl_stack[run_slot] = r.stack_word;
            tbl_state[run_slot] = SLOT_READY;
            tbl_state[idx] = SLOT_RUNNING;
            run_slot = idx;
            o.status = ST_OK;
            o.task_id = tbl_id[idx];
            o.slot_index = 3'(idx);
            o.switched = 1'b1;
            o.resume_stack = tbl_stack[idx];
          end
        end
      end
      default: begin
        wipe_table();
        o.status = ST_OK;
      end
    endcase
    n_req[r.req_type]++;
    if (o.status < 5) n_status[o.status]++;
    if (o.switched) n_switches++;
    return o;
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic req_t make_req(input req_type_e kind, input logic page,
                                    input logic [31:0] word);
    req_t r;
    r.req_type = kind;
    r.page_granted = page;
    r.stack_word = word;
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int unsigned gap;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    expected_q.push_back(apply_request(r));
    n_sent++;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_edge_cases();
    send_request(make_req(REQ_YIELD, 1'b1, 32'h0000_0000));
    send_request(make_req(REQ_START, 1'b0, 32'hFFFF_FFFF));
    send_request(make_req(REQ_CREATE, 1'b0, 32'h1234_5678));
    send_request(make_req(REQ_CREATE, 1'b1, 32'h0000_0000));
    send_request(make_req(REQ_START, 1'b1, 32'h0000_0000));
    send_request(make_req(REQ_YIELD, 1'b0, 32'hFFFF_FFFF));
    send_request(make_req(REQ_CREATE, 1'b1, 32'hFFFF_FFFF));
    send_request(make_req(REQ_YIELD, 1'b1, 32'h5A5A_5A5A));
    send_request(make_req(REQ_START, 1'b0, 32'h0000_0000));
    send_request(make_req(REQ_YIELD, 1'b1, 32'hA5A5_A5A5));
    for (int unsigned k = 0; k < 6; k++)
      send_request(make_req(REQ_CREATE, 1'b1, 32'hC0DE_0000 + k));
    send_request(make_req(REQ_CREATE, 1'b1, 32'h8000_0001));
    send_request(make_req(REQ_CREATE, 1'b0, 32'h7FFF_FFFE));
    send_request(make_req(REQ_YIELD, 1'b0, 32'h0000_0000));
    send_request(make_req(REQ_YIELD, 1'b1, 32'hFFFF_FFFF));
    send_request(make_req(REQ_CLEAR, 1'b1, 32'hFFFF_FFFF));
    send_request(make_req(REQ_YIELD, 1'b1, 32'h0BAD_F00D));
    send_request(make_req(REQ_START, 1'b1, 32'h0000_0000));
    send_request(make_req(REQ_CREATE, 1'b1, 32'h0000_0001));
    wait_for_results();
  endtask

  // Fill the table to a chosen depth, start it and rotate through every task.
  task automatic test_full_rotation();
    int unsigned depth;
    for (int unsigned round = 0; round < 10; round++) begin
      depth = (round < SLOTS) ? round + 1 : SLOTS;
      quiet = (round % 3 == 0);
      send_request(make_req(REQ_CLEAR, 1'($urandom_range(0, 1)), $urandom()));
      for (int unsigned k = 0; k < depth; k++)
        send_request(make_req(REQ_CREATE, 1'b1, pick_word()));
      send_request(make_req(REQ_START, 1'($urandom_range(0, 1)), $urandom()));
      repeat (depth + $urandom_range(1, 6))
        send_request(make_req(REQ_YIELD, 1'($urandom_range(0, 1)), pick_word()));
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    req_t r;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 120 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n % 250 == 249) wait_for_results();
      r.page_granted = ($urandom_range(0, 9) != 0);
      r.stack_word = pick_word();
      pick = $urandom_range(0, 99);
      if (pick < 32) r.req_type = REQ_CREATE;
      else if (pick < 40) r.req_type = REQ_START;
      else if (pick < 97) r.req_type = REQ_YIELD;
      else r.req_type = REQ_CLEAR;
      send_request(r);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    quiet = 1'b0;
    n_errors = 0;
    n_words = 0;
    n_sent = 0;
    n_switches = 0;
    n_req = '{default: 0};
    n_status = '{default: 0};
    next_id = 32'd1;
    wipe_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    test_full_rotation();
    test_random_traffic(1750);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("missing results", 32'(expected_q.size()), 32'd0);

    $display("Sent %0d requests (%0d create, %0d start, %0d yield, %0d clear), %0d switches.",
             n_sent, n_req[REQ_CREATE], n_req[REQ_START], n_req[REQ_YIELD],
             n_req[REQ_CLEAR], n_switches);
    $display("Statuses: ok %0d, full %0d, no page %0d, none ready %0d, not started %0d.",
             n_status[ST_OK], n_status[ST_FULL], n_status[ST_NO_PAGE],
             n_status[ST_NONE_READY], n_status[ST_NOT_STARTED]);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
